>>> design/fir_pkg.sv
// ---------------------------------------------------------------------------
// FIR filter package
// Shared constants, codes and types of the direct-form FIR filter unit.
// ---------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

   // Filter size and number format.
   localparam int TAPS           = 25;
   localparam int SAMPLE_BITS    = 16;
   localparam int FRAC_BITS      = SAMPLE_BITS - 1;
   localparam int TAP_INDEX_BITS = 5;

   // Coefficient memory addressing and tap counter width.
   localparam int TAP_AW = (TAPS > 1) ? $clog2(TAPS) : 1;

   // Sample history ring: one entry per past sample that a tap uses.
   localparam int HIST_DEPTH = (TAPS > 1) ? TAPS - 1 : 1;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int FILL_W     = $clog2(HIST_DEPTH + 1);

   // Accumulator width fits the exact sum of all products plus the rounding bias.
   localparam int PROD_W = 2 * SAMPLE_BITS;
   localparam int ACC_W  = PROD_W + TAP_AW + 1;

   // Item kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // One tap issued by the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic vld;
      logic use_x;
      logic coef_ok;
      logic hist_ok;
   } issue_type;

   // Control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic      start;
      issue_type issue;
   } mac_ctrl_type;

   // Status from the multiply-accumulate unit to the sequencer.
   typedef struct packed {
      logic busy;
   } mac_status_type;

endpackage

`default_nettype wire

>>> design/fir_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_ram #(
   parameter  int WIDTH  = 16,
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/fir_mac.sv
// ---------------------------------------------------------------------------
// FIR multiply-accumulate unit
// Selects operands from memory data, multiplies, accumulates, and rounds
// and saturates the finished sum.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_mac
   import fir_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mac_ctrl_type           ctrl,
   input  wire logic [SAMPLE_BITS-1:0] coef_rdata,
   input  wire logic [SAMPLE_BITS-1:0] hist_rdata,
   input  wire sample_type             sample,
   output mac_status_type              status,
   output sample_type                  filtered,
   output logic                        saturated
);

   issue_type                 s1_ff;
   logic                      prod_vld_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   sample_type                coef_op;
   sample_type                x_op;
   logic signed [ACC_W-1:0]   rounded;
   logic signed [ACC_W-1:0]   shifted;
   logic                      fits;

   // Tap flags are registered alongside the memory read, so they line up with the read data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         s1_ff       <= ctrl.issue;
         prod_vld_ff <= s1_ff.vld;
      end
   end

   // Entries never written read as zero.
   always_comb begin
      coef_op = s1_ff.coef_ok ? sample_type'(coef_rdata) : '0;
      if (s1_ff.use_x) begin
         x_op = sample;
      end else if (s1_ff.hist_ok) begin
         x_op = sample_type'(hist_rdata);
      end else begin
         x_op = '0;
      end
   end

   // Product register.
   always_ff @(posedge clock) begin
      prod_ff <= coef_op * x_op;
   end

   // Accumulator, cleared when a sample starts.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign status.busy = s1_ff.vld | prod_vld_ff;

   // Round to nearest, drop the fraction, and clip to the sample range.
   always_comb begin
      rounded = acc_ff + (ACC_W'(1) <<< (FRAC_BITS - 1));
      shifted = rounded >>> FRAC_BITS;
      fits    = (&shifted[ACC_W-1:SAMPLE_BITS-1]) | ~(|shifted[ACC_W-1:SAMPLE_BITS-1]);
      if (fits) begin
         filtered  = shifted[SAMPLE_BITS-1:0];
         saturated = 1'b0;
      end else begin
         filtered  = {shifted[ACC_W-1], {(SAMPLE_BITS-1){~shifted[ACC_W-1]}}};
         saturated = 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> design/fir_seq.sv
// ---------------------------------------------------------------------------
// FIR sequencer
// Takes input beats, steps one tap per cycle through the coefficient and
// history memories, and keeps the history ring pointer and fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_seq
   import fir_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_kind,
   input  wire logic [TAP_INDEX_BITS-1:0] req_tap_index,
   input  wire logic                      req_first_sample,
   input  wire mac_status_type            mac_status,
   input  wire logic                      out_free,
   output logic                           req_ready,
   output mac_ctrl_type                   mac_ctrl,
   output logic                           coef_we,
   output logic [TAP_AW-1:0]              coef_waddr,
   output logic [TAP_AW-1:0]              coef_raddr,
   output logic [HIST_AW-1:0]             hist_raddr,
   output logic                           hist_we,
   output logic [HIST_AW-1:0]             hist_waddr,
   output logic                           finish
);

   state_type            state_ff, state_in;
   logic [TAP_AW-1:0]    cnt_ff, cnt_in;
   logic [HIST_AW-1:0]   hist_ra_ff, hist_ra_in;
   logic [HIST_AW-1:0]   wp_ff, wp_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [TAPS-1:0]      coef_vld_ff, coef_vld_in;
   logic                 req_fire;
   logic                 sample_fire;
   logic                 last_tap;

   assign req_fire    = req_valid & req_ready;
   assign sample_fire = req_fire & (req_kind == KIND_SAMPLE);
   assign last_tap    = (32'(cnt_ff) == TAPS - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_status.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      req_ready                = (state_ff == ST_IDLE);
      mac_ctrl.start           = sample_fire;
      mac_ctrl.issue.vld       = (state_ff == ST_RUN);
      mac_ctrl.issue.use_x     = (cnt_ff == '0);
      mac_ctrl.issue.coef_ok   = coef_vld_ff[cnt_ff];
      mac_ctrl.issue.hist_ok   = (cnt_ff != '0) && (32'(cnt_ff) <= 32'(fill_ff));
      coef_we                  = req_fire && (req_kind == KIND_COEF)
                                 && (32'(req_tap_index) < TAPS);
      coef_waddr               = TAP_AW'(req_tap_index);
      coef_raddr               = cnt_ff;
      hist_raddr               = hist_ra_ff;
      finish                   = (state_ff == ST_FINISH) && out_free;
      hist_we                  = finish && (TAPS > 1);
      hist_waddr               = wp_ff;
   end

   // Tap counter, history pointers, fill count and coefficient valid bits.
   always_comb begin
      cnt_in      = cnt_ff;
      hist_ra_in  = hist_ra_ff;
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      coef_vld_in = coef_vld_ff;
      if (coef_we) begin
         coef_vld_in[coef_waddr] = 1'b1;
      end
      if (sample_fire) begin
         cnt_in     = '0;
         hist_ra_in = (wp_ff == '0) ? HIST_AW'(HIST_DEPTH - 1) : HIST_AW'(wp_ff - 1'b1);
         if (req_first_sample) begin
            fill_in = '0;
         end
      end
      if ((state_ff == ST_RUN) && !last_tap) begin
         cnt_in = TAP_AW'(cnt_ff + 1'b1);
      end
      // The most recent past sample is read by the tap after the first.
      if ((state_ff == ST_RUN) && (cnt_ff != '0)) begin
         hist_ra_in = (hist_ra_ff == '0) ? HIST_AW'(HIST_DEPTH - 1)
                                        : HIST_AW'(hist_ra_ff - 1'b1);
      end
      if (finish) begin
         wp_in = (32'(wp_ff) == HIST_DEPTH - 1) ? '0 : HIST_AW'(wp_ff + 1'b1);
         if (32'(fill_ff) < HIST_DEPTH) begin
            fill_in = FILL_W'(fill_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         hist_ra_ff  <= '0;
         wp_ff       <= '0;
         fill_ff     <= '0;
         coef_vld_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         hist_ra_ff  <= hist_ra_in;
         wp_ff       <= wp_in;
         fill_ff     <= fill_in;
         coef_vld_ff <= coef_vld_in;
      end
   end

endmodule

`default_nettype wire

>>> design/fir_filter_direct_form_unit.sv
// ---------------------------------------------------------------------------
// Direct-form FIR filter unit
// A 25-tap FIR filter with Q1.15 samples and coefficients, built around
// a coefficient memory, a sample history memory and one shared
// multiply-accumulate unit.
// ---------------------------------------------------------------------------
// A coefficient load beat is taken at once and gives no result; a
// coefficient never loaded counts as zero. A sample beat is worked on in
// full before the next beat is taken: the single multiply-accumulate unit
// steps through one tap per cycle, reading the coefficient memory and the
// history memory in the same cycle, and the memory read, product register
// and accumulator are drained before the rounded result is written to the
// output register, once that register is free. A sample with first_sample
// set starts from an empty history. The result is rounded to nearest, and
// clipped to the Q1.15 range with rsp_saturated set. The next beat may be
// taken while a result still waits on the output.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_filter_direct_form_unit
   import fir_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_kind,
   input  wire logic [TAP_INDEX_BITS-1:0] req_tap_index,
   input  wire logic signed [SAMPLE_BITS-1:0] req_coef_value,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                      req_first_sample,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]  rsp_filtered,
   output logic                           rsp_saturated
);

   mac_ctrl_type             mac_ctrl;
   mac_status_type           mac_status;
   logic                     coef_we;
   logic [TAP_AW-1:0]        coef_waddr;
   logic [TAP_AW-1:0]        coef_raddr;
   logic [HIST_AW-1:0]       hist_raddr;
   logic                     hist_we;
   logic [HIST_AW-1:0]       hist_waddr;
   logic [SAMPLE_BITS-1:0]   coef_rdata;
   logic [SAMPLE_BITS-1:0]   hist_rdata;
   logic                     finish;
   logic                     out_free;
   sample_type               sample_ff;
   sample_type               mac_filtered;
   logic                     mac_saturated;
   logic                     rsp_valid_ff;
   sample_type               rsp_filtered_ff;
   logic                     rsp_saturated_ff;

   assign out_free = ~rsp_valid_ff | rsp_ready;

   fir_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_kind         (req_kind),
      .req_tap_index    (req_tap_index),
      .req_first_sample (req_first_sample),
      .mac_status       (mac_status),
      .out_free         (out_free),
      .req_ready        (req_ready),
      .mac_ctrl         (mac_ctrl),
      .coef_we          (coef_we),
      .coef_waddr       (coef_waddr),
      .coef_raddr       (coef_raddr),
      .hist_raddr       (hist_raddr),
      .hist_we          (hist_we),
      .hist_waddr       (hist_waddr),
      .finish           (finish)
   );

   // Coefficient memory.
   fir_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_coef_value),
      .rd_en   (mac_ctrl.issue.vld),
      .rd_addr (coef_raddr),
      .rd_data (coef_rdata)
   );

   // Sample history ring.
   fir_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (sample_ff),
      .rd_en   (mac_ctrl.issue.vld),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   // Current sample, held for the whole filter pass.
   always_ff @(posedge clock) begin
      if (mac_ctrl.start) begin
         sample_ff <= req_sample;
      end
   end

   fir_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .coef_rdata (coef_rdata),
      .hist_rdata (hist_rdata),
      .sample     (sample_ff),
      .status     (mac_status),
      .filtered   (mac_filtered),
      .saturated  (mac_saturated)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_filtered_ff  <= mac_filtered;
         rsp_saturated_ff <= mac_saturated;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_filtered  = rsp_filtered_ff;
   assign rsp_saturated = rsp_saturated_ff;

endmodule

`default_nettype wire

>>> design/fir_chk.sv
// ---------------------------------------------------------------------------
// FIR filter port checker
// Watches the ports of the filter unit over time.
// ---------------------------------------------------------------------------
`default_nettype none

module fir_chk
   import fir_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic                      req_kind,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   input  wire logic                      rsp_saturated
);

   // No result is pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result beat holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_filtered)
                                  && $stable(rsp_saturated))
      else $error("stalled result beat changed");

   // A clipped result is one of the two range limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_filtered == {1'b0, {(SAMPLE_BITS-1){1'b1}}}
         || rsp_filtered == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
      else $error("saturated result is not a range limit");

   // A sample beat keeps the unit busy on the next cycle.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_SAMPLE |=> !req_ready)
      else $error("input taken again during a filter pass");

   // A coefficient load completes at once.
   a_coef_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_COEF |=> req_ready)
      else $error("coefficient load stalled the input");

endmodule

bind fir_filter_direct_form_unit fir_chk u_fir_chk (.*);

`default_nettype wire
